@@ rtl/dead_reckoning_pose_integrator_assert.svh @@
// Assertion macros shared by the checker of the pose integrator.
`ifndef DEAD_RECKONING_POSE_INTEGRATOR_ASSERT_SVH
`define DEAD_RECKONING_POSE_INTEGRATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRPI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drpi assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DRPI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drpi assertion failed");

`endif

@@ rtl/drpi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package drpi_pkg;

  // Field widths of the request and result channels.
  localparam int VEL_W       = 16;
  localparam int HEAD_W      = 20;
  localparam int DT_W        = 20;
  localparam int WORLD_W     = 48;
  localparam int HOUT_W      = 19;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 120;
  localparam int OUT_TUSER_W = 2;

  // Internal datapath widths.
  localparam int ANG_W   = 21;
  localparam int Z_W     = 20;
  localparam int CORD_W  = 32;
  localparam int PROD_W  = 64;
  localparam int DELTA_W = 40;

  localparam int VEL_FRAC   = 14;
  localparam int GAIN_FRAC  = 30;
  localparam int ATAN_IDX_W = 5;

  // Angles in units of 2^-16 radian.
  localparam logic signed [ANG_W-1:0] PI_A     = 21'sd205887;
  localparam logic signed [ANG_W-1:0] TWO_PI_A = 21'sd411775;
  localparam logic signed [Z_W-1:0]   PI_Z     = 20'sd205887;
  localparam logic signed [Z_W-1:0]   HALF_PI_Z = 20'sd102944;

  // Reciprocal of the rotator gain in Q30.
  localparam logic signed [CORD_W-1:0] INV_GAIN_Q30 = 32'sd652032874;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROTATE,
    ST_GAIN_X,
    ST_GAIN_Y,
    ST_SCALE_X,
    ST_SCALE_Y,
    ST_ACC_X,
    ST_ACC_Y,
    ST_WRITE
  } state_t;

  // Arctangent of 2^-i in units of 2^-16 radian.
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      5'd0:    a = 20'sd51472;
      5'd1:    a = 20'sd30386;
      5'd2:    a = 20'sd16055;
      5'd3:    a = 20'sd8150;
      5'd4:    a = 20'sd4091;
      5'd5:    a = 20'sd2047;
      5'd6:    a = 20'sd1024;
      5'd7:    a = 20'sd512;
      5'd8:    a = 20'sd256;
      5'd9:    a = 20'sd128;
      5'd10:   a = 20'sd64;
      5'd11:   a = 20'sd32;
      5'd12:   a = 20'sd16;
      5'd13:   a = 20'sd8;
      5'd14:   a = 20'sd4;
      5'd15:   a = 20'sd2;
      5'd16:   a = 20'sd1;
      default: a = 20'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dead_reckoning_pose_integrator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A request passes through ST_PREP, the CORDIC rotation in ST_ROTATE, ST_GAIN_X, ST_GAIN_Y,
// ST_SCALE_X, ST_SCALE_Y, ST_ACC_X, ST_ACC_Y and ST_WRITE before m_tvalid; a zero step goes
// straight to ST_WRITE. A new request is taken only in ST_IDLE, once the last result is loaded;
// the rotator iterates once per cycle and the single shared multiplier is used four times.
// Reset (rst, synchronous, active high) clears the stored position and the handshake state.

module dead_reckoning_pose_integrator #(
  parameter int CORDIC_STEPS  = 16,
  parameter int POSITION_BITS = 48
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // s_tdata, from bit 0 up: body_vel_x[15:0], body_vel_y[15:0], heading_in[19:0],
  // step_time[19:0]
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [drpi_pkg::IN_TDATA_W-1:0]     s_tdata,
  // m_tdata, from bit 0 up: world_x[47:0], world_y[47:0], heading_out[18:0], 5 zero bits
  // m_tuser, from bit 0 up: rejected, saturated
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [drpi_pkg::OUT_TDATA_W-1:0]         m_tdata,
  output logic [drpi_pkg::OUT_TUSER_W-1:0]         m_tuser
);

  // The iteration counter is sized for the rotation steps 0 to CORDIC_STEPS - 1.
  localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

  // The accumulation is done one bit wider than either operand, so an overflow is
  // always visible before clamping.
  localparam int SUM_W = ((POSITION_BITS > drpi_pkg::DELTA_W) ? POSITION_BITS
                                                              : drpi_pkg::DELTA_W) + 1;
  localparam logic signed [SUM_W-1:0] POS_MAX = (SUM_W'(1) <<< (POSITION_BITS - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);

  localparam logic signed [drpi_pkg::PROD_W-1:0] RND_GAIN =
    drpi_pkg::PROD_W'(1) <<< (drpi_pkg::GAIN_FRAC - 1);
  localparam logic signed [drpi_pkg::PROD_W-1:0] RND_VEL =
    drpi_pkg::PROD_W'(1) <<< (drpi_pkg::VEL_FRAC - 1);

  // Request fields.
  logic signed [drpi_pkg::VEL_W-1:0]  in_vx;
  logic signed [drpi_pkg::VEL_W-1:0]  in_vy;
  logic signed [drpi_pkg::HEAD_W-1:0] in_h;
  logic        [drpi_pkg::DT_W-1:0]   in_dt;

  assign in_vx = s_tdata[15:0];
  assign in_vy = s_tdata[31:16];
  assign in_h  = s_tdata[51:32];
  assign in_dt = s_tdata[71:52];

  // Sequencer.
  drpi_pkg::state_t state;
  drpi_pkg::state_t state_next;
  logic             out_load;

  // Datapath registers.
  logic signed [drpi_pkg::HOUT_W-1:0]  hw;
  logic        [drpi_pkg::DT_W-1:0]    dt;
  logic signed [drpi_pkg::CORD_W-1:0]  x;
  logic signed [drpi_pkg::CORD_W-1:0]  y;
  logic signed [drpi_pkg::Z_W-1:0]     z;
  logic        [ITER_W-1:0]            iter;
  logic signed [drpi_pkg::PROD_W-1:0]  prod;
  logic signed [drpi_pkg::CORD_W-1:0]  wq_x;
  logic signed [drpi_pkg::CORD_W-1:0]  wq_y;
  logic signed [drpi_pkg::DELTA_W-1:0] dx;
  logic signed [drpi_pkg::DELTA_W-1:0] dy;
  logic signed [POSITION_BITS-1:0]     pos_x;
  logic signed [POSITION_BITS-1:0]     pos_y;
  logic                                rej;
  logic                                sat_acc;

  // Heading wrap. The input range is narrow enough that one correction by 2*pi always
  // brings the heading into plus or minus pi.
  logic signed [drpi_pkg::ANG_W-1:0] h_ext;
  logic signed [drpi_pkg::ANG_W-1:0] h_wr;

  always_comb begin
    h_ext = drpi_pkg::ANG_W'(in_h);
    if (h_ext > drpi_pkg::PI_A) begin
      h_wr = h_ext - drpi_pkg::TWO_PI_A;
    end else if (h_ext < -drpi_pkg::PI_A) begin
      h_wr = h_ext + drpi_pkg::TWO_PI_A;
    end else begin
      h_wr = h_ext;
    end
  end

  // One CORDIC micro-rotation per cycle: the shifted copies come from a barrel shift by
  // the iteration count, and the angle step from the arctangent table.
  logic signed [drpi_pkg::CORD_W-1:0] xs;
  logic signed [drpi_pkg::CORD_W-1:0] ys;
  logic signed [drpi_pkg::Z_W-1:0]    atan_step;

  assign xs        = x >>> iter;
  assign ys        = y >>> iter;
  assign atan_step = drpi_pkg::atan_q16(drpi_pkg::ATAN_IDX_W'(iter));

  // The one multiplier is shared by the gain correction of both axes and the scaling of
  // both axes by the step; its operands are chosen by the sequencer state.
  logic signed [drpi_pkg::CORD_W-1:0] mul_a;
  logic signed [drpi_pkg::CORD_W-1:0] mul_b;
  logic signed [drpi_pkg::PROD_W-1:0] mul_p;

  always_comb begin
    case (state)
      drpi_pkg::ST_GAIN_X: begin
        mul_a = x;
        mul_b = drpi_pkg::INV_GAIN_Q30;
      end
      drpi_pkg::ST_GAIN_Y: begin
        mul_a = y;
        mul_b = drpi_pkg::INV_GAIN_Q30;
      end
      drpi_pkg::ST_SCALE_X: begin
        mul_a = wq_x;
        mul_b = drpi_pkg::CORD_W'(dt);
      end
      default: begin
        mul_a = wq_y;
        mul_b = drpi_pkg::CORD_W'(dt);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Both roundings are half up: add half an output unit and take the floor.
  logic signed [drpi_pkg::PROD_W-1:0] rnd_gain_sum;
  logic signed [drpi_pkg::PROD_W-1:0] rnd_vel_sum;

  assign rnd_gain_sum = prod + RND_GAIN;
  assign rnd_vel_sum  = prod + RND_VEL;

  // Shared saturating accumulator, used for x and then for y.
  logic signed [POSITION_BITS-1:0]     acc_pos;
  logic signed [drpi_pkg::DELTA_W-1:0] acc_delta;
  logic signed [SUM_W-1:0]             acc_sum;
  logic signed [POSITION_BITS-1:0]     acc_res;
  logic                                acc_clip;

  always_comb begin
    if (state == drpi_pkg::ST_ACC_Y) begin
      acc_pos   = pos_y;
      acc_delta = dy;
    end else begin
      acc_pos   = pos_x;
      acc_delta = dx;
    end
    acc_sum = SUM_W'(acc_pos) + SUM_W'(acc_delta);
    if (acc_sum > POS_MAX) begin
      acc_res  = POSITION_BITS'(POS_MAX);
      acc_clip = 1'b1;
    end else if (acc_sum < POS_MIN) begin
      acc_res  = POSITION_BITS'(POS_MIN);
      acc_clip = 1'b1;
    end else begin
      acc_res  = POSITION_BITS'(acc_sum);
      acc_clip = 1'b0;
    end
  end

  // Sequencer: next state, request ready and the load of the result register. A finished
  // result waits in ST_WRITE only while the previous one has not yet been taken.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      drpi_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (in_dt == '0) ? drpi_pkg::ST_WRITE : drpi_pkg::ST_PREP;
        end
      end
      drpi_pkg::ST_PREP: begin
        state_next = drpi_pkg::ST_ROTATE;
      end
      drpi_pkg::ST_ROTATE: begin
        if (iter == ITER_LAST) begin
          state_next = drpi_pkg::ST_GAIN_X;
        end
      end
      drpi_pkg::ST_GAIN_X: begin
        state_next = drpi_pkg::ST_GAIN_Y;
      end
      drpi_pkg::ST_GAIN_Y: begin
        state_next = drpi_pkg::ST_SCALE_X;
      end
      drpi_pkg::ST_SCALE_X: begin
        state_next = drpi_pkg::ST_SCALE_Y;
      end
      drpi_pkg::ST_SCALE_Y: begin
        state_next = drpi_pkg::ST_ACC_X;
      end
      drpi_pkg::ST_ACC_X: begin
        state_next = drpi_pkg::ST_ACC_Y;
      end
      drpi_pkg::ST_ACC_Y: begin
        state_next = drpi_pkg::ST_WRITE;
      end
      drpi_pkg::ST_WRITE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = drpi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = drpi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drpi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Position state. Only the accumulate steps change it, so a rejected request leaves it
  // exactly as it was.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
    end else if (state == drpi_pkg::ST_ACC_X) begin
      pos_x <= acc_res;
    end else if (state == drpi_pkg::ST_ACC_Y) begin
      pos_y <= acc_res;
    end
  end

  // Working registers of one request.
  always_ff @(posedge clk) begin
    case (state)
      drpi_pkg::ST_IDLE: begin
        // The velocity enters the rotator in Q14 mm/s.
        hw      <= drpi_pkg::HOUT_W'(h_wr);
        z       <= drpi_pkg::Z_W'(h_wr);
        x       <= drpi_pkg::CORD_W'(in_vx) <<< drpi_pkg::VEL_FRAC;
        y       <= drpi_pkg::CORD_W'(in_vy) <<< drpi_pkg::VEL_FRAC;
        dt      <= in_dt;
        rej     <= (in_dt == '0);
        sat_acc <= 1'b0;
        iter    <= '0;
      end
      drpi_pkg::ST_PREP: begin
        // Headings beyond a right angle are folded back by turning the vector half round.
        if (z > drpi_pkg::HALF_PI_Z) begin
          x <= -x;
          y <= -y;
          z <= z - drpi_pkg::PI_Z;
        end else if (z < -drpi_pkg::HALF_PI_Z) begin
          x <= -x;
          y <= -y;
          z <= z + drpi_pkg::PI_Z;
        end
      end
      drpi_pkg::ST_ROTATE: begin
        if (z >= 0) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_step;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_step;
        end
        iter <= iter + ITER_W'(1);
      end
      drpi_pkg::ST_GAIN_X: begin
        prod <= mul_p;
      end
      drpi_pkg::ST_GAIN_Y: begin
        prod <= mul_p;
        wq_x <= rnd_gain_sum[drpi_pkg::GAIN_FRAC +: drpi_pkg::CORD_W];
      end
      drpi_pkg::ST_SCALE_X: begin
        prod <= mul_p;
        wq_y <= rnd_gain_sum[drpi_pkg::GAIN_FRAC +: drpi_pkg::CORD_W];
      end
      drpi_pkg::ST_SCALE_Y: begin
        // Q14 mm/s times microseconds, rounded to whole nanometres.
        prod <= mul_p;
        dx   <= rnd_vel_sum[drpi_pkg::VEL_FRAC +: drpi_pkg::DELTA_W];
      end
      drpi_pkg::ST_ACC_X: begin
        dy      <= rnd_vel_sum[drpi_pkg::VEL_FRAC +: drpi_pkg::DELTA_W];
        sat_acc <= acc_clip;
      end
      drpi_pkg::ST_ACC_Y: begin
        sat_acc <= sat_acc | acc_clip;
      end
      default: begin
      end
    endcase
  end

  // Result register. The position is sign-extended to 64 bits so that a narrow position
  // still gives a signed 48-bit coordinate and a wide one gives its low 48 bits.
  logic signed [63:0] pos_x64;
  logic signed [63:0] pos_y64;

  assign pos_x64 = 64'(pos_x);
  assign pos_y64 = 64'(pos_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'b0, hw, pos_y64[drpi_pkg::WORLD_W-1:0], pos_x64[drpi_pkg::WORLD_W-1:0]};
      m_tuser <= {sat_acc & ~rej, rej};
    end
  end

endmodule

`default_nettype wire

@@ rtl/drpi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "dead_reckoning_pose_integrator_assert.svh"

module drpi_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [drpi_pkg::IN_TDATA_W-1:0] s_tdata,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [drpi_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic [drpi_pkg::OUT_TUSER_W-1:0] m_tuser
);

  logic s_req_live;

  // The request data is only meaningful while a request is offered.
  assign s_req_live = s_tvalid & (s_tdata[0] | ~s_tdata[0]);

  // A result that is not taken stays offered and unchanged.
  `DRPI_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // Each request keeps the block busy for at least the following cycle.
  `DRPI_ASSERT_NXT(a_busy_after_req, clk, rst, s_req_live && s_tready, !s_tready)

  // A rejected step never reports a clipped position.
  `DRPI_ASSERT_IMP(a_rej_no_sat, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[1]))

  // The reported heading is always within plus or minus pi.
  `DRPI_ASSERT_IMP(a_heading_range, clk, rst, m_tvalid, ($signed(m_tdata[114:96]) <= 19'sd205887) && ($signed(m_tdata[114:96]) >= -19'sd205887))

endmodule

bind dead_reckoning_pose_integrator drpi_checker u_drpi_checker (.*);

`default_nettype wire
